// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the frame filter RTL
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Types and constants of the command frame filter with duplicate cache.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned CACHE_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned THR_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 168;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [WIN_W-1:0] WINDOW_RST    = WIN_W'(2000);
  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(50);

  typedef enum logic [1:0] {
    VERDICT_ACCEPT     = 2'd0,
    VERDICT_NOT_CMD    = 2'd1,
    VERDICT_OTHER_DEST = 2'd2,
    VERDICT_DUPLICATE  = 2'd3
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDRESS     = 2'd0,
    CFG_WINDOW_MS       = 2'd1,
    CFG_PRUNE_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_INSERT
  } back_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] own_address;
    logic [WIN_W-1:0]  window_ms;
    logic [THR_W-1:0]  prune_threshold;
  } cfg_t;

  // classified frame handed from front to back
  typedef struct packed {
    verdict_e          verdict;
    logic [ADDR_W-1:0] sender;
    logic [ID_W-1:0]   msg_id;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    verdict_e          verdict;
    logic [ADDR_W-1:0] ack_target;
    logic [ID_W-1:0]   ack_id;
    logic [CODE_W-1:0] command_out;
  } result_t;

endpackage

// ===== sv/cfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_front
// Accepts frames, unpacks them and settles the command and destination checks.
// ----------------------------------------------------------------------------
module cfr_front (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [cfr_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                              s_axis_tuser_i,
  input  logic [cfr_pkg::ADDR_W-1:0]        own_address_i,
  input  logic                              push_ready_i,
  output logic                              push_valid_o,
  output cfr_pkg::item_t                    push_item_o
);

  logic [cfr_pkg::ADDR_W-1:0] dest;

  assign dest            = s_axis_tdata_i[95:48];
  assign s_axis_tready_o = push_ready_i;
  assign push_valid_o    = s_axis_tvalid_i;

  always_comb begin
    push_item_o.sender = s_axis_tdata_i[47:0];
    push_item_o.msg_id = s_axis_tdata_i[127:96];
    push_item_o.code   = s_axis_tdata_i[135:128];
    push_item_o.now    = s_axis_tdata_i[167:136];
    priority if (!s_axis_tuser_i) begin
      push_item_o.verdict = cfr_pkg::VERDICT_NOT_CMD;
    end else if (dest != '0 && dest != own_address_i) begin
      push_item_o.verdict = cfr_pkg::VERDICT_OTHER_DEST;
    end else begin
      // survivor: the back end does the cache lookup
      push_item_o.verdict = cfr_pkg::VERDICT_ACCEPT;
    end
  end

endmodule

// ===== sv/cfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_queue
// Short FIFO of classified frames between front and back.
// ----------------------------------------------------------------------------
module cfr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cfr_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output cfr_pkg::item_t pop_item_o
);

  localparam int unsigned PW = (cfr_pkg::QUEUE_DEPTH > 1) ? $clog2(cfr_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(cfr_pkg::QUEUE_DEPTH + 1);

  cfr_pkg::item_t slots_q [cfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != CW'(cfr_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(cfr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(cfr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/cfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_back
// Cache engine: lookup walk, prune sweep, insertion and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfr_back #(
  parameter int unsigned CACHE_ENTRIES = cfr_pkg::CACHE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfr_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  input  cfr_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output cfr_pkg::result_t res_o
);

  localparam int unsigned IW    = $clog2(CACHE_ENTRIES);
  localparam int unsigned OCC_W = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned CW    = (OCC_W > cfr_pkg::THR_W) ? OCC_W : cfr_pkg::THR_W;

  cfr_pkg::entry_t cache_mem [CACHE_ENTRIES];

  cfr_pkg::back_state_e state_q, state_d;
  logic [IW:0]          cnt_q, cnt_d;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;
  cfr_pkg::entry_t      rdata_q;
  cfr_pkg::item_t       cur_q;
  logic                 sweep_en_q;
  logic [OCC_W-1:0]     occ_q, occ_d;

  // walk accumulators
  logic                      hit_q, hit_d;
  logic                      free_found_q, free_found_d;
  logic [IW-1:0]             free_idx_q, free_idx_d;
  logic [IW-1:0]             old_idx_q, old_idx_d;
  logic [cfr_pkg::TIME_W-1:0] best_age_q, best_age_d;
  logic [OCC_W-1:0]          swept_q, swept_d;

  logic                      out_vld_q;
  cfr_pkg::result_t          out_q;

  logic                       issue, last, expired, match, load_out, acc_clr;
  logic [cfr_pkg::TIME_W-1:0] age;
  logic                       mem_we;
  logic [IW-1:0]              mem_wa;
  cfr_pkg::entry_t            mem_wd;
  cfr_pkg::result_t           out_d;

  assign issue   = (state_q == cfr_pkg::ST_LOOK || state_q == cfr_pkg::ST_SWEEP)
                   && (cnt_q < (IW+1)'(CACHE_ENTRIES));
  assign last    = rd_vld_q && (rd_idx_q == IW'(CACHE_ENTRIES - 1));
  assign age     = cur_q.now - rdata_q.stamp;
  assign expired = (age >= cfr_pkg::TIME_W'(cfg_i.window_ms));
  assign match   = rdata_q.valid && (rdata_q.address == cur_q.sender)
                   && (rdata_q.id == cur_q.msg_id);

  // per-entry evaluation during the lookup walk
  always_comb begin
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    old_idx_d    = old_idx_q;
    best_age_d   = best_age_q;
    swept_d      = swept_q;
    if (state_q == cfr_pkg::ST_LOOK && rd_vld_q) begin
      hit_d = hit_q || match;
      if (!free_found_q && (!rdata_q.valid || (sweep_en_q && expired))) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
      if (sweep_en_q && rdata_q.valid && expired) begin
        swept_d = swept_q + 1'b1;
      end
      // oldest entry, lowest index on ties
      if (rd_idx_q == '0 || age > best_age_q) begin
        best_age_d = age;
        old_idx_d  = rd_idx_q;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfr_pkg::ST_CLEAR: begin
        if (cnt_q[IW-1:0] == IW'(CACHE_ENTRIES - 1)) state_d = cfr_pkg::ST_IDLE;
      end
      cfr_pkg::ST_IDLE: begin
        if (q_valid_i && !out_vld_q && q_item_i.verdict == cfr_pkg::VERDICT_ACCEPT) begin
          state_d = cfr_pkg::ST_LOOK;
        end
      end
      cfr_pkg::ST_LOOK: begin
        if (last) begin
          priority if (hit_d) begin
            state_d = cfr_pkg::ST_IDLE;
          end else if (swept_d != '0) begin
            state_d = cfr_pkg::ST_SWEEP;
          end else begin
            state_d = cfr_pkg::ST_INSERT;
          end
        end
      end
      cfr_pkg::ST_SWEEP: begin
        if (last) state_d = cfr_pkg::ST_INSERT;
      end
      cfr_pkg::ST_INSERT: state_d = cfr_pkg::ST_IDLE;
      default: state_d = cfr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = rd_idx_q;
    mem_wd   = rdata_q;
    load_out = 1'b0;
    acc_clr  = 1'b0;
    cnt_d    = issue ? cnt_q + 1'b1 : cnt_q;
    occ_d    = occ_q;
    out_d    = '{verdict: cfr_pkg::VERDICT_ACCEPT, ack_target: '0, ack_id: '0,
                 command_out: '0};
    unique case (state_q)
      cfr_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[IW-1:0];
        mem_wd = '0;
        cnt_d  = cnt_q + 1'b1;
      end
      cfr_pkg::ST_IDLE: begin
        cnt_d   = '0;
        acc_clr = 1'b1;
        if (q_valid_i && !out_vld_q) begin
          q_pop_o = 1'b1;
          if (q_item_i.verdict != cfr_pkg::VERDICT_ACCEPT) begin
            load_out      = 1'b1;
            out_d.verdict = q_item_i.verdict;
          end
        end
      end
      cfr_pkg::ST_LOOK: begin
        if (last) begin
          cnt_d = '0;
          if (hit_d) begin
            load_out      = 1'b1;
            out_d.verdict = cfr_pkg::VERDICT_DUPLICATE;
          end
        end
      end
      cfr_pkg::ST_SWEEP: begin
        if (rd_vld_q && rdata_q.valid && expired) begin
          mem_we       = 1'b1;
          mem_wd.valid = 1'b0;
        end
      end
      cfr_pkg::ST_INSERT: begin
        mem_we   = 1'b1;
        mem_wa   = free_found_q ? free_idx_q : old_idx_q;
        mem_wd   = '{valid: 1'b1, address: cur_q.sender, id: cur_q.msg_id,
                     stamp: cur_q.now};
        occ_d    = occ_q - swept_q + OCC_W'(free_found_q);
        load_out = 1'b1;
        out_d    = '{verdict: cfr_pkg::VERDICT_ACCEPT, ack_target: cur_q.sender,
                     ack_id: cur_q.msg_id, command_out: cur_q.code};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cfr_pkg::ST_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      occ_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= issue;
      occ_q    <= occ_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IW-1:0];
    if (q_pop_o) begin
      cur_q      <= q_item_i;
      sweep_en_q <= (CW'(occ_q) > CW'(cfg_i.prune_threshold));
    end
    if (acc_clr) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      old_idx_q    <= '0;
      best_age_q   <= '0;
      swept_q      <= '0;
    end else begin
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      old_idx_q    <= old_idx_d;
      best_age_q   <= best_age_d;
      swept_q      <= swept_d;
    end
    if (load_out) out_q <= out_d;
  end

  // cache store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) cache_mem[mem_wa] <= mem_wd;
    rdata_q <= cache_mem[cnt_q[IW-1:0]];
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  `CFR_ASSERT_IMP(a_occ_bound, 1'b1, occ_q <= OCC_W'(CACHE_ENTRIES),
                  "occupancy exceeds cache size")
  `CFR_ASSERT_IMP(a_pop_idle, q_pop_o, state_q == cfr_pkg::ST_IDLE && !out_vld_q,
                  "queue popped while back end busy")
  `CFR_ASSERT_NXT(a_full_overwrite, state_q == cfr_pkg::ST_INSERT && !free_found_q,
                  occ_q == $past(occ_q), "overwrite of oldest entry changed occupancy")

endmodule

// ===== sv/command_frame_filter_dedup_core.sv =====
`timescale 1ns / 1ps
// Rejected frames (not a command, other destination) skip the cache and get their result
// from the result register. Cache lookups walk every entry through one memory read port;
// a duplicate ends after the walk, a miss adds the insert, and a miss that prunes adds a
// second walk for the write-back before the insert. One frame is in the engine at a time
// and the next enters only once the result has transferred; a two-entry queue keeps the
// input open. After reset the cache is cleared entry by entry before the first lookup.
// ----------------------------------------------------------------------------
// command_frame_filter_dedup_core
// Command frame receive filter with a bounded duplicate-suppression cache.
// ----------------------------------------------------------------------------
module command_frame_filter_dedup_core #(
  parameter int unsigned CACHE_ENTRIES = cfr_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sender_address, dest_address, message_id, command_code, time_now
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cfr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // is_command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // ack_target, ack_id, command_out
  output logic [cfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // verdict
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cfr_pkg::ADDR_W-1:0]          cfg_data_i
);

  cfr_pkg::cfg_t    cfg_q;
  cfr_pkg::item_t   push_item, pop_item;
  cfr_pkg::result_t res;
  logic             push_valid, push_ready, pop_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address     <= '0;
      cfg_q.window_ms       <= cfr_pkg::WINDOW_RST;
      cfg_q.prune_threshold <= cfr_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfr_pkg::CFG_OWN_ADDRESS:     cfg_q.own_address     <= cfg_data_i;
        cfr_pkg::CFG_WINDOW_MS:       cfg_q.window_ms       <= cfg_data_i[cfr_pkg::WIN_W-1:0];
        cfr_pkg::CFG_PRUNE_THRESHOLD: cfg_q.prune_threshold <= cfg_data_i[cfr_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  cfr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .own_address_i   (cfg_q.own_address),
    .push_ready_i    (push_ready),
    .push_valid_o    (push_valid),
    .push_item_o     (push_item)
  );

  cfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  cfr_back #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (pop_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.verdict;
  assign m_axis_tdata = {res.command_out, res.ack_id, res.ack_target};

endmodule

// ===== dv/command_frame_filter_dedup_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_filter_dedup_core_tb
// Drives command frames through the filter, predicts verdicts with a local
// duplicate cache and checks every result transfer in order.
// ----------------------------------------------------------------------------
module command_frame_filter_dedup_core_tb;

  localparam int unsigned N_ENT = cfr_pkg::CACHE_ENTRIES_DEF;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam logic [cfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [cfr_pkg::ADDR_W-1:0] sender;
    logic [cfr_pkg::ADDR_W-1:0] dest;
    logic                       cmd;
    logic [cfr_pkg::ID_W-1:0]   id;
    logic [cfr_pkg::CODE_W-1:0] code;
    logic [cfr_pkg::TIME_W-1:0] now;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [cfr_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [cfr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [cfr_pkg::ADDR_W-1:0] cfg_data_i = '0;

  command_frame_filter_dedup_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [cfr_pkg::ADDR_W-1:0] own_addr_q = '0;
  logic [cfr_pkg::WIN_W-1:0]  window_q = cfr_pkg::WINDOW_RST;
  logic [cfr_pkg::THR_W-1:0]  thresh_q = cfr_pkg::THRESHOLD_RST;
  bit                         ent_vld[N_ENT];
  logic [cfr_pkg::ADDR_W-1:0] ent_addr[N_ENT];
  logic [cfr_pkg::ID_W-1:0]   ent_id[N_ENT];
  logic [cfr_pkg::TIME_W-1:0] ent_stamp[N_ENT];
  int unsigned                ent_count = 0;

  cfr_pkg::result_t verdict_q[$];
  int unsigned errors = 0;

  // stimulus knobs
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  logic [cfr_pkg::ADDR_W-1:0] sender_pool[8];
  logic [cfr_pkg::ID_W-1:0]   id_base;
  logic [cfr_pkg::TIME_W-1:0] clock_ms;

  function automatic cfr_pkg::result_t filter_frame(frame_t f);
    cfr_pkg::result_t r;
    bit hit;
    bit found;
    int unsigned slot;
    logic [cfr_pkg::TIME_W-1:0] best;
    logic [cfr_pkg::TIME_W-1:0] age;
    r = '0;
    hit = 0;
    found = 0;
    slot = 0;
    best = '0;
    if (!f.cmd) begin
      r.verdict = cfr_pkg::VERDICT_NOT_CMD;
      return r;
    end
    if (f.dest != '0 && f.dest != own_addr_q) begin
      r.verdict = cfr_pkg::VERDICT_OTHER_DEST;
      return r;
    end
    for (int i = 0; i < N_ENT; i++)
      if (ent_vld[i] && ent_addr[i] == f.sender && ent_id[i] == f.id) hit = 1;
    if (hit) begin
      r.verdict = cfr_pkg::VERDICT_DUPLICATE;
      return r;
    end
    if (ent_count > thresh_q) begin
      for (int i = 0; i < N_ENT; i++) begin
        age = f.now - ent_stamp[i];
        if (ent_vld[i] && age >= cfr_pkg::TIME_W'(window_q)) begin
          ent_vld[i] = 0;
          ent_count--;
        end
      end
    end
    for (int i = 0; i < N_ENT; i++)
      if (!found && !ent_vld[i]) begin
        found = 1;
        slot = i;
      end
    if (found) begin
      ent_count++;
    end else begin
      // full store: oldest entry goes, lowest index on ties
      for (int i = 0; i < N_ENT; i++) begin
        age = f.now - ent_stamp[i];
        if (i == 0 || age > best) begin
          best = age;
          slot = i;
        end
      end
    end
    ent_vld[slot] = 1;
    ent_addr[slot] = f.sender;
    ent_id[slot] = f.id;
    ent_stamp[slot] = f.now;
    r.verdict = cfr_pkg::VERDICT_ACCEPT;
    r.ack_target = f.sender;
    r.ack_id = f.id;
    r.command_out = f.code;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    cfr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(m_axis_tuser), 64'(0));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tuser != want.verdict)
          report_mismatch("verdict", 64'(m_axis_tuser), 64'(want.verdict));
        if (m_axis_tdata[47:0] != want.ack_target)
          report_mismatch("ack_target", 64'(m_axis_tdata[47:0]), 64'(want.ack_target));
        if (m_axis_tdata[79:48] != want.ack_id)
          report_mismatch("ack_id", 64'(m_axis_tdata[79:48]), 64'(want.ack_id));
        if (m_axis_tdata[87:80] != want.command_out)
          report_mismatch("command_out", 64'(m_axis_tdata[87:80]), 64'(want.command_out));
      end
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("command_frame_filter_dedup_core test failed");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = f.cmd;
    s_axis_tdata = {f.now, f.code, f.id, f.dest, f.sender};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.push_back(filter_frame(f));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [cfr_pkg::CFG_IDX_W-1:0] idx,
                           logic [cfr_pkg::ADDR_W-1:0] val);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      cfr_pkg::CFG_OWN_ADDRESS:     own_addr_q = val;
      cfr_pkg::CFG_WINDOW_MS:       window_q = val[cfr_pkg::WIN_W-1:0];
      cfr_pkg::CFG_PRUNE_THRESHOLD: thresh_q = val[cfr_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic frame_t make_frame(logic cmd, logic [cfr_pkg::ADDR_W-1:0] dest,
                                        logic [cfr_pkg::ADDR_W-1:0] sender,
                                        logic [cfr_pkg::ID_W-1:0] id,
                                        logic [cfr_pkg::CODE_W-1:0] code,
                                        logic [cfr_pkg::TIME_W-1:0] now);
    frame_t f;
    f.cmd = cmd;
    f.dest = dest;
    f.sender = sender;
    f.id = id;
    f.code = code;
    f.now = now;
    return f;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  // mostly well-formed frames from a small sender/id pool, some noise
  function automatic frame_t rand_frame(int unsigned id_span, int unsigned step_max);
    frame_t f;
    clock_ms += $urandom_range(step_max);
    if ($urandom_range(99) < 80) begin
      f.cmd = 1'b1;
      f.dest = $urandom_range(1) ? own_addr_q : '0;
      f.sender = sender_pool[$urandom_range(7)];
      f.id = id_base + $urandom_range(id_span - 1);
    end else begin
      f.cmd = 1'($urandom_range(1));
      f.dest = $urandom_range(3) == 0 ? rand48() : ($urandom_range(1) ? own_addr_q : '0);
      f.sender = rand48();
      f.id = $urandom;
    end
    f.code = 8'($urandom);
    f.now = clock_ms;
    return f;
  endfunction

  task automatic run_random(int unsigned n, int unsigned id_span, int unsigned step_max);
    int unsigned mode;
    for (int i = 0; i < n; i++) begin
      // rotate through idle mixes in stretches
      mode = (i / 25) % 4;
      send_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 15 : 0;
      recv_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 15 : 0;
      send_frame(rand_frame(id_span, step_max));
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic new_pools();
    foreach (sender_pool[i]) sender_pool[i] = rand48();
    id_base = $urandom;
  endtask

  task automatic test_directed();
    logic [cfr_pkg::ADDR_W-1:0] own;
    own = 48'h1234_5678_9abc;
    send_frame(make_frame(1'b0, rand48(), rand48(), $urandom, 8'hff, 32'd5));
    send_frame(make_frame(1'b1, '1, '0, '0, '0, '0));
    send_frame(make_frame(1'b1, '0, '0, '0, '0, '0));
    send_frame(make_frame(1'b1, '0, '0, '0, 8'h11, 32'd1));
    send_frame(make_frame(1'b1, '0, '1, '1, '1, '1));
    // stale entry still counts as duplicate
    send_frame(make_frame(1'b1, '0, '1, '1, 8'h22, 32'h7fff_ffff));
    // not-command wins over other destination
    send_frame(make_frame(1'b0, '1, '1, '1, 8'h33, 32'd9));
    write_cfg(cfr_pkg::CFG_OWN_ADDRESS, own);
    send_frame(make_frame(1'b1, own, 48'h5, 32'h5, 8'h44, 32'd10));
    send_frame(make_frame(1'b1, own ^ 48'h1, 48'h6, 32'h6, 8'h55, 32'd11));
    send_frame(make_frame(1'b1, '0, 48'h5, 32'h5, 8'h66, 32'd12));
    send_frame(make_frame(1'b1, own, 48'h5, 32'h6, 8'h77, 32'd13));
    write_cfg(CFG_UNUSED, '1);
    send_frame(make_frame(1'b1, own, 48'h7, 32'h7, 8'h88, 32'd14));
    write_cfg(cfr_pkg::CFG_OWN_ADDRESS, '1);
    send_frame(make_frame(1'b1, '1, 48'h7, 32'h8, 8'h99, 32'd15));
    send_frame(make_frame(1'b1, own, 48'h7, 32'h9, 8'haa, 32'd16));
    wait_drained();
  endtask

  task automatic test_sweep_every_miss();
    write_cfg(cfr_pkg::CFG_OWN_ADDRESS, rand48());
    write_cfg(cfr_pkg::CFG_WINDOW_MS, 48'd500);
    write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, '0);
    new_pools();
    run_random(150, 12, 200);
    wait_drained();
  endtask

  task automatic test_full_store();
    // no sweeping and many distinct ids: store fills and overwrites
    write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, 48'd64);
    write_cfg(cfr_pkg::CFG_WINDOW_MS, '0);
    new_pools();
    run_random(150, 40, 50);
    write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, 48'd127);
    write_cfg(cfr_pkg::CFG_WINDOW_MS, 48'hffff);
    run_random(80, 60, 3000);
    wait_drained();
  endtask

  task automatic test_window_zero_sweep();
    // every entry expired once a sweep runs
    write_cfg(cfr_pkg::CFG_WINDOW_MS, '0);
    write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, 48'd10);
    new_pools();
    run_random(100, 20, 10);
    wait_drained();
  endtask

  task automatic test_receiver_holdoff();
    write_cfg(cfr_pkg::CFG_WINDOW_MS, 48'd2000);
    write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, 48'd30);
    new_pools();
    @(negedge clk_i);
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_frame(rand_frame(16, 400));
    wait_drained();
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 2; k++) begin
      write_cfg(cfr_pkg::CFG_OWN_ADDRESS, rand48());
      write_cfg(cfr_pkg::CFG_WINDOW_MS, 48'($urandom_range(4000)));
      write_cfg(cfr_pkg::CFG_PRUNE_THRESHOLD, 48'($urandom_range(64)));
      new_pools();
      // exercise time wrap too
      clock_ms = 32'hffff_ffff - $urandom_range(20000);
      run_random(100, 24, 600);
      wait_drained();
    end
  endtask

  initial begin
    clock_ms = '0;
    foreach (ent_vld[i]) ent_vld[i] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_sweep_every_miss();
    test_full_store();
    test_window_zero_sweep();
    test_receiver_holdoff();
    test_random_settings();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("command_frame_filter_dedup_core test passed");
    end else begin
      $display("command_frame_filter_dedup_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cfr_pkg.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/command_frame_filter_dedup_core.sv
dv/command_frame_filter_dedup_core_tb.sv
